### design/asdt_pkg.sv
// Shared types, constants and codes for the axis smoothing, deadband and trim block.
`timescale 1ns / 1ps
`default_nettype none
package asdt_pkg;

	localparam int AXES_DEF = 7;
	localparam int WINDOW_DEF = 10;
	localparam int DW = 10;

	localparam logic [DW-1:0] FULL_SCALE = 10'd1023;
	localparam logic [13:0] TRIM_RESET = 14'd8192;
	localparam logic [13:0] TRIM_CEIL = 14'd16368;

	localparam logic [9:0] RAW_MIN_RST = 10'd196;
	localparam logic [9:0] RAW_MAX_RST = 10'd1023;
	localparam logic [9:0] THR_RST = 10'd1;
	localparam logic [6:0] MASK_RST = 7'd3;
	localparam logic [2:0] TRIM_AXIS_RST = 3'd2;
	localparam logic [4:0] TRIM_SCALE_RST = 5'd8;

	typedef enum logic [2:0] {
		CFG_RAW_MIN = 3'd0,
		CFG_RAW_MAX = 3'd1,
		CFG_THRESHOLD = 3'd2,
		CFG_MASK = 3'd3,
		CFG_TRIM_AXIS = 3'd4,
		CFG_TRIM_SCALE = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic func;
		logic [2:0] axis;
		logic [9:0] sample;
	} item_t;

	typedef struct packed {
		logic [2:0] out_axis;
		logic [9:0] smoothed;
		logic [9:0] mapped;
		logic [9:0] axis_value;
	} result_t;

	typedef struct packed {
		logic [9:0] raw_min;
		logic [9:0] raw_max;
		logic [9:0] deadband_threshold;
		logic [6:0] deadband_mask;
		logic [2:0] trim_axis;
		logic [4:0] trim_scale;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_PRIME,
		ST_MUL,
		ST_MEAN,
		ST_MAP,
		ST_DIV,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic acc;
		logic prime;
		logic mul;
		logic mean;
		logic map_init;
		logic div_step;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic ax_ok;
		logic func;
		logic prime_last;
		logic map_short;
		logic div_last;
		logic out_block;
	} sts_t;

endpackage
`default_nettype wire

### design/asdt_ctrl.sv
// Controller state machine that sequences one beat through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module asdt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire asdt_pkg::sts_t sts,
	output asdt_pkg::cmd_t cmd
);
	import asdt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && sts.ax_ok) begin
					state_d = sts.func ? ST_PRIME : ST_READ;
				end
			end
			ST_READ: state_d = ST_SUM;
			ST_SUM: state_d = ST_MUL;
			ST_PRIME: begin
				if (sts.prime_last) begin
					state_d = ST_MEAN;
				end
			end
			ST_MUL: state_d = ST_MEAN;
			ST_MEAN: state_d = ST_MAP;
			ST_MAP: state_d = sts.map_short ? ST_UPD : ST_DIV;
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (!sts.out_block) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.load = item_valid;
			end
			ST_READ: cmd.rd = 1'b1;
			ST_SUM: cmd.acc = 1'b1;
			ST_PRIME: cmd.prime = 1'b1;
			ST_MUL: cmd.mul = 1'b1;
			ST_MEAN: cmd.mean = 1'b1;
			ST_MAP: cmd.map_init = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_UPD: cmd.update = !sts.out_block;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

### design/asdt_dp.sv
// Datapath: window memory, running sums, mean, range divider, deadband and trim state.
`timescale 1ns / 1ps
`default_nettype none
module asdt_dp #(
	parameter int AXES = asdt_pkg::AXES_DEF,
	parameter int WINDOW = asdt_pkg::WINDOW_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire asdt_pkg::cfg_t cfg,
	input wire asdt_pkg::item_t item,
	input wire asdt_pkg::cmd_t cmd,
	output asdt_pkg::sts_t sts,
	input wire logic result_ready,
	output logic result_valid,
	output asdt_pkg::result_t result
);
	import asdt_pkg::*;

	localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int PW = $clog2(WINDOW);
	localparam int DEPTH = AXES * WINDOW;
	localparam int MAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = $clog2(1023 * WINDOW + 1);
	localparam int K = SW + $clog2(WINDOW);
	localparam int RW = SW + 2;
	localparam logic [RW-1:0] RECIP = RW'((2 ** K + WINDOW - 1) / WINDOW);

	logic [9:0] mem [DEPTH];
	logic [9:0] rd_q;
	logic [DEPTH-1:0] vld_q;
	logic old_vld_q;

	logic func_q;
	logic [2:0] axis_q;
	logic [9:0] smp_q;
	logic [PW-1:0] pcnt_q;
	logic [SW-1:0] sum_q [AXES];
	logic [PW-1:0] ptr_q [AXES];
	logic [9:0] held_q [AXES];
	logic [SW-1:0] sumr_q;
	logic [SW+RW-1:0] prod_q;
	logic [9:0] mean_q;
	logic [9:0] rem_q;
	logic [9:0] num_q;
	logic [9:0] den_q;
	logic [9:0] quo_q;
	logic [3:0] dcnt_q;
	logic [13:0] acc_q;
	logic [9:0] prev_q;

	logic [AXW-1:0] axi;
	logic [PW-1:0] ptr_cur;
	logic [MAW-1:0] base;
	logic [MAW-1:0] rd_addr;
	logic [MAW-1:0] wr_addr;
	logic we;
	logic [9:0] old_smp;
	logic [SW-1:0] new_sum;
	logic [9:0] diff;
	logic [19:0] numer;
	logic short_zero;
	logic short_full;
	logic [10:0] trial;
	logic trial_ge;
	logic is_trim;
	logic [7:0] mask8;
	logic [9:0] held_cur;
	logic [9:0] db_diff;
	logic signed [10:0] delta;
	logic signed [16:0] tprod;
	logic signed [17:0] tsum;
	logic [13:0] acc_new;
	logic [9:0] held_new;
	logic [9:0] val;

	assign axi = AXW'(axis_q);
	assign ptr_cur = ptr_q[axi];
	assign base = MAW'(MAW'(axis_q) * MAW'(WINDOW));
	assign rd_addr = base + MAW'(ptr_cur);
	assign wr_addr = cmd.prime ? (base + MAW'(pcnt_q)) : rd_addr;
	assign we = cmd.prime || cmd.acc;
	assign old_smp = old_vld_q ? rd_q : 10'd0;
	assign new_sum = sum_q[axi] - SW'(old_smp) + SW'(smp_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= smp_q;
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign diff = mean_q - cfg.raw_min;
	assign numer = {diff, 10'd0} - {10'd0, diff};
	assign short_zero = (cfg.raw_max <= cfg.raw_min) || (mean_q <= cfg.raw_min);
	assign short_full = (mean_q >= cfg.raw_max);
	assign trial = {rem_q, num_q[9]};
	assign trial_ge = (trial >= {1'b0, den_q});

	assign is_trim = (cfg.trim_axis == axis_q);
	assign mask8 = {1'b0, cfg.deadband_mask};
	assign held_cur = held_q[axi];
	assign db_diff = (quo_q > held_cur) ? (quo_q - held_cur) : (held_cur - quo_q);
	assign delta = $signed({1'b0, mean_q}) - $signed({1'b0, prev_q});
	assign tprod = delta * $signed({1'b0, cfg.trim_scale});
	assign tsum = $signed({4'd0, acc_q}) + {tprod[16], tprod};

	always_comb begin
		if (tsum < 18'sd0) begin
			acc_new = 14'd0;
		end else if (tsum > $signed({4'd0, TRIM_CEIL})) begin
			acc_new = TRIM_CEIL;
		end else begin
			acc_new = tsum[13:0];
		end
		held_new = held_cur;
		if (func_q || !mask8[axis_q] || (db_diff >= cfg.deadband_threshold)) begin
			held_new = quo_q;
		end
		if (is_trim) begin
			val = func_q ? acc_q[13:4] : acc_new[13:4];
		end else begin
			val = held_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
				ptr_q[a] <= '0;
				held_q[a] <= '0;
			end
			acc_q <= TRIM_RESET;
			prev_q <= '0;
			result_valid <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.acc) begin
				sum_q[axi] <= new_sum;
				ptr_q[axi] <= (ptr_cur == PW'(WINDOW - 1)) ? '0 : ptr_cur + 1'b1;
			end
			if (cmd.prime) begin
				sum_q[axi] <= SW'(smp_q * SW'(WINDOW));
			end
			if (cmd.update) begin
				if (!(is_trim && !func_q)) begin
					held_q[axi] <= held_new;
				end
				if (is_trim) begin
					prev_q <= mean_q;
					if (!func_q) begin
						acc_q <= acc_new;
					end
				end
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= item.func;
			axis_q <= item.axis;
			smp_q <= item.sample;
			pcnt_q <= '0;
		end
		if (cmd.prime) begin
			pcnt_q <= pcnt_q + 1'b1;
		end
		if (cmd.rd) begin
			old_vld_q <= vld_q[rd_addr];
		end
		if (cmd.acc) begin
			sumr_q <= new_sum;
		end
		if (cmd.mul) begin
			prod_q <= sumr_q * RECIP;
		end
		if (cmd.mean) begin
			mean_q <= func_q ? smp_q : 10'(prod_q >> K);
		end
		if (cmd.map_init) begin
			rem_q <= numer[19:10];
			num_q <= numer[9:0];
			den_q <= cfg.raw_max - cfg.raw_min;
			dcnt_q <= '0;
			quo_q <= short_zero ? 10'd0 : (short_full ? FULL_SCALE : 10'd0);
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? 10'(trial - {1'b0, den_q}) : trial[9:0];
			num_q <= {num_q[8:0], 1'b0};
			quo_q <= {quo_q[8:0], trial_ge};
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.update) begin
			result.out_axis <= axis_q;
			result.smoothed <= mean_q;
			result.mapped <= quo_q;
			result.axis_value <= val;
		end
	end

	assign sts.ax_ok = (int'(item.axis) < AXES);
	assign sts.func = item.func;
	assign sts.prime_last = (pcnt_q == PW'(WINDOW - 1));
	assign sts.map_short = short_zero || short_full;
	assign sts.div_last = (dcnt_q == 4'd9);
	assign sts.out_block = result_valid && !result_ready;

endmodule
`default_nettype wire

### design/axis_smoothing_deadband_trim.sv
// Top level: configuration registers, controller and datapath of the axis smoother.
// Each accepted beat for an axis below AXES yields one result beat; a beat for a
// higher axis is dropped. A normal sample goes from acceptance to the result
// register through a window memory read, the running-sum update, a reciprocal
// multiply for the mean, and a ten-step restoring divider for the range mapping.
// When the mean lies at or outside the range ends, or the range is empty, the
// divider is skipped. A prime beat writes the window one entry per cycle, takes
// its sample as the mean and maps it the same way. A result that is not taken
// holds the block in its last step. The next beat is accepted once the result
// is loaded, while that result may still wait to be taken.
`timescale 1ns / 1ps
`default_nettype none
module axis_smoothing_deadband_trim #(
	parameter int AXES = asdt_pkg::AXES_DEF,
	parameter int WINDOW = asdt_pkg::WINDOW_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire asdt_pkg::item_t item,
	output logic result_valid,
	input wire logic result_ready,
	output asdt_pkg::result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [9:0] cfg_data
);
	import asdt_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_min <= RAW_MIN_RST;
			cfg_q.raw_max <= RAW_MAX_RST;
			cfg_q.deadband_threshold <= THR_RST;
			cfg_q.deadband_mask <= MASK_RST;
			cfg_q.trim_axis <= TRIM_AXIS_RST;
			cfg_q.trim_scale <= TRIM_SCALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RAW_MIN: cfg_q.raw_min <= cfg_data;
				CFG_RAW_MAX: cfg_q.raw_max <= cfg_data;
				CFG_THRESHOLD: cfg_q.deadband_threshold <= cfg_data;
				CFG_MASK: cfg_q.deadband_mask <= cfg_data[6:0];
				CFG_TRIM_AXIS: cfg_q.trim_axis <= cfg_data[2:0];
				CFG_TRIM_SCALE: cfg_q.trim_scale <= cfg_data[4:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	asdt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.sts(sts),
		.cmd(cmd)
	);

	asdt_dp #(
		.AXES(AXES),
		.WINDOW(WINDOW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item(item),
		.cmd(cmd),
		.sts(sts),
		.result_ready(result_ready),
		.result_valid(result_valid),
		.result(result)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !(result_valid && !result_ready))
		else $error("Result register loaded while a beat is still pending.");

	a_update_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> result_valid)
		else $error("Result beat not presented after an update.");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && (int'(item.axis) < AXES)) |=> !item_ready)
		else $error("Input taken again while a beat is in progress.");

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the axis smoothing, deadband and trim block.
`timescale 1ns / 1ps
module tb_top;
	import asdt_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;

	axis_smoothing_deadband_trim uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	localparam int NAX = 7;
	localparam int WIN = 10;

	logic [9:0] rmin, rmax, thr;
	logic [6:0] mask;
	logic [2:0] trim_ax;
	logic [4:0] tscale;
	logic [9:0] win_mem [NAX][WIN];
	logic [13:0] win_sum [NAX];
	int win_ptr [NAX];
	logic [9:0] held [NAX];
	int trim_acc;
	logic [9:0] prev_trim_mean;

	item_t pending_items[$];
	result_t expected_results[$];
	int errors = 0;
	bit calm = 1'b0;
	bit item_taken = 1'b0;
	int item_gap = 0;
	int result_stall = 0;
	int cycles = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	function automatic logic [9:0] range_map(input logic [9:0] x);
		int q;
		if (rmax <= rmin || x <= rmin) return 10'd0;
		q = (int'(x - rmin) * 1023) / int'(rmax - rmin);
		return q > 1023 ? 10'd1023 : q[9:0];
	endfunction

	function automatic void smoothing_reset();
		rmin = RAW_MIN_RST; rmax = RAW_MAX_RST; thr = THR_RST;
		mask = MASK_RST; trim_ax = TRIM_AXIS_RST; tscale = TRIM_SCALE_RST;
		for (int a = 0; a < NAX; a++) begin
			for (int i = 0; i < WIN; i++) win_mem[a][i] = '0;
			win_sum[a] = '0; win_ptr[a] = 0; held[a] = '0;
		end
		trim_acc = 8192;
		prev_trim_mean = '0;
	endfunction

	function automatic void predict_axis(input item_t it);
		result_t r;
		logic [9:0] mean, mp, val, d;
		int ax;
		bit trim;
		ax = it.axis;
		if (ax >= NAX) return;
		trim = (trim_ax == it.axis);
		if (it.func) begin
			for (int i = 0; i < WIN; i++) win_mem[ax][i] = it.sample;
			win_sum[ax] = it.sample * WIN;
			mean = it.sample;
			mp = range_map(mean);
			held[ax] = mp;
			if (trim) begin
				prev_trim_mean = mean;
				val = trim_acc >> 4;
			end else val = held[ax];
		end else begin
			win_sum[ax] = win_sum[ax] - win_mem[ax][win_ptr[ax]] + it.sample;
			win_mem[ax][win_ptr[ax]] = it.sample;
			win_ptr[ax] = (win_ptr[ax] + 1) % WIN;
			mean = win_sum[ax] / WIN;
			mp = range_map(mean);
			if (trim) begin
				trim_acc += (int'(mean) - int'(prev_trim_mean)) * int'(tscale);
				prev_trim_mean = mean;
				if (trim_acc < 0) trim_acc = 0;
				if (trim_acc > 16368) trim_acc = 16368;
				val = trim_acc >> 4;
			end else begin
				if (mask[ax]) begin
					d = mp > held[ax] ? mp - held[ax] : held[ax] - mp;
					if (d >= thr) held[ax] = mp;
				end else held[ax] = mp;
				val = held[ax];
			end
		end
		r.out_axis = it.axis; r.smoothed = mean; r.mapped = mp; r.axis_value = val;
		expected_results.push_back(r);
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_taken) begin
				if (item_gap > 0) begin
					item_gap--;
					item_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0) item_gap = $urandom_range(1, 4);
				end else begin
					item_valid <= 1'b0;
				end
			end
			if (result_stall > 0) begin
				result_stall--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) result_stall = $urandom_range(1, 4);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		item_taken = item_valid && item_ready;
		if (item_taken) predict_axis(item);
		if (result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				report("unexpected beat on axis", 32'(result.out_axis), 32'd0);
			end else begin
				result_t w;
				w = expected_results.pop_front();
				if (result.out_axis !== w.out_axis)
					report("out_axis", 32'(result.out_axis), 32'(w.out_axis));
				if (result.smoothed !== w.smoothed)
					report("smoothed", 32'(result.smoothed), 32'(w.smoothed));
				if (result.mapped !== w.mapped)
					report("mapped", 32'(result.mapped), 32'(w.mapped));
				if (result.axis_value !== w.axis_value)
					report("axis_value", 32'(result.axis_value), 32'(w.axis_value));
			end
		end
		if (cycles > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic drain();
		while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [9:0] v);
		@(negedge clk);
		cfg_index <= idx; cfg_data <= v; cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_RAW_MIN: rmin = v;
			CFG_RAW_MAX: rmax = v;
			CFG_THRESHOLD: thr = v;
			CFG_MASK: mask = v[6:0];
			CFG_TRIM_AXIS: trim_ax = v[2:0];
			CFG_TRIM_SCALE: tscale = v[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t make_item(input logic f, input logic [2:0] a, input logic [9:0] s);
		item_t it;
		it.func = f; it.axis = a; it.sample = s;
		return it;
	endfunction

	task automatic queue_random(input int n);
		logic [2:0] a;
		for (int i = 0; i < n; i++) begin
			a = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
			pending_items.push_back(make_item($urandom_range(0, 15) == 0, a,
				$urandom_range(0, 3) == 0 ? 10'($urandom_range(0, 1) * 1023) : 10'($urandom)));
		end
	endtask

	initial begin
		smoothing_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int a = 0; a < 8; a++) begin
			pending_items.push_back(make_item(1'b0, 3'(a), 10'd1023));
			pending_items.push_back(make_item(1'b1, 3'(a), a[0] ? 10'd0 : 10'd1023));
		end
		pending_items.push_back(make_item(1'b0, 3'd2, 10'd0));
		pending_items.push_back(make_item(1'b0, 3'd0, 10'h155));
		pending_items.push_back(make_item(1'b0, 3'd0, 10'h2AA));
		drain();
		write_reg(CFG_RAW_MIN, 10'd600);
		write_reg(CFG_RAW_MAX, 10'd100);
		write_reg(CFG_MASK, 10'd127);
		write_reg(CFG_TRIM_AXIS, 10'd2);
		write_reg(CFG_TRIM_SCALE, 10'd31);
		write_reg(CFG_THRESHOLD, 10'd0);
		pending_items.push_back(make_item(1'b0, 3'd1, 10'd700));
		pending_items.push_back(make_item(1'b1, 3'd2, 10'd1023));
		pending_items.push_back(make_item(1'b0, 3'd2, 10'd0));
		queue_random(200);
		drain();
		write_reg(CFG_RAW_MIN, 10'd0);
		write_reg(CFG_RAW_MAX, 10'd1023);
		write_reg(CFG_THRESHOLD, 10'd1023);
		write_reg(CFG_MASK, 10'd0);
		write_reg(CFG_TRIM_AXIS, 10'd7);
		write_reg(CFG_TRIM_SCALE, 10'd0);
		queue_random(250);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_RAW_MIN, 10'($urandom_range(0, 400)));
			write_reg(CFG_RAW_MAX, 10'($urandom_range(300, 1023)));
			write_reg(CFG_THRESHOLD, 10'($urandom_range(0, 40)));
			write_reg(CFG_MASK, 10'($urandom_range(0, 127)));
			write_reg(CFG_TRIM_AXIS, 10'($urandom_range(0, 6)));
			write_reg(CFG_TRIM_SCALE, 10'($urandom_range(0, 16)));
			if (ph == 3) calm = 1'b1;
			queue_random(230);
			drain();
		end
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
